// File: hdl/assert_macros.svh
// Assertion macros used by the bind checker in bscu_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of i_clk, off while i_rst_n is low.
`define CHK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same check, named for properties whose consequent holds in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons, msg) \
    `CHK_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: hdl/bscu_pkg.sv
`timescale 1ns / 1ps

package bscu_pkg;

    // Store geometry.
    localparam int MAX_SAMPLES = 1024;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);

    // Fixed field widths.
    localparam int CNT_W  = 11;
    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;
    localparam int RES_W  = 64;

    // Sum of up to MAX_SAMPLES values, its magnitude, and the band width.
    localparam int SUM_W = DATA_W + ADDR_W;
    localparam int MAG_W = SUM_W - 1;
    localparam int WID_W = DATA_W + 1;

    // The sum magnitude is multiplied in a low and a high slice.
    localparam int HI_W   = MAG_W - DATA_W;
    localparam int PROD_W = MAG_W + DATA_W;

    localparam logic [CNT_W-1:0] SAMPLE_COUNT_RST = CNT_W'(1024);

    // Request codes.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_LO,
        SCAN_HI
    } t_scan_state;

    typedef enum logic [2:0] {
        MUL_IDLE,
        MUL_LO,
        MUL_HI,
        MUL_SAT,
        MUL_OUT
    } t_mul_state;

    // Handoff from the scan sequencer to the multiply unit.
    typedef struct packed {
        logic                    go;
        logic signed [SUM_W-1:0] sum;
        logic signed [WID_W-1:0] width;
    } t_mul_req;

endpackage

// File: hdl/bscu_ram.sv
`timescale 1ns / 1ps

module bscu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/bscu_scan.sv
`timescale 1ns / 1ps

module bscu_scan import bscu_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_go,
    input  logic [CNT_W-1:0]         i_count,
    input  logic signed [DATA_W-1:0] i_bound_low,
    input  logic signed [DATA_W-1:0] i_bound_high,
    output logic [ADDR_W-1:0]        o_rd_addr,
    input  logic [DATA_W-1:0]        i_rd_x,
    input  logic [DATA_W-1:0]        i_rd_y,
    output logic                     o_busy,
    output t_mul_req                 o_req
);

    t_scan_state r_state, n_state;

    logic [ADDR_W-1:0]        r_addr, n_addr;
    logic                     r_dv, n_dv;
    logic [ADDR_W-1:0]        r_didx, n_didx;
    logic [ADDR_W-1:0]        r_last, n_last;
    logic [ADDR_W-1:0]        r_start, n_start;
    logic signed [DATA_W-1:0] r_low, n_low;
    logic signed [DATA_W-1:0] r_high, n_high;
    logic signed [SUM_W-1:0]  r_acc, n_acc;
    logic signed [DATA_W-1:0] r_y_first, n_y_first;
    t_mul_req                 r_req, n_req;

    logic signed [DATA_W-1:0] bound_sel;
    logic signed [DATA_W-1:0] rd_x;
    logic signed [DATA_W-1:0] rd_y;
    logic                     cmp_ge;
    logic                     at_last;
    logic                     in_range;
    int                       n_eff;

    assign rd_x = $signed(i_rd_x);
    assign rd_y = $signed(i_rd_y);

    // The shared compare unit: the stored abscissa against the active bound.
    assign bound_sel = (r_state == SCAN_LO) ? r_low : r_high;
    assign cmp_ge    = (rd_x >= bound_sel);

    // Range tests on the index of the word that is on the read port.
    assign in_range = (r_didx < r_last);
    assign at_last  = ((ADDR_W + 1)'(r_didx) + (ADDR_W + 1)'(1)) >= (ADDR_W + 1)'(r_last);

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SCAN_IDLE;
            r_dv    <= 1'b0;
            r_req   <= '0;
        end else begin
            r_state <= n_state;
            r_dv    <= n_dv;
            r_req   <= n_req;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_didx    <= n_didx;
        r_last    <= n_last;
        r_start   <= n_start;
        r_low     <= n_low;
        r_high    <= n_high;
        r_acc     <= n_acc;
        r_y_first <= n_y_first;
    end

    // Sequencer: scan for the lower bound, then for the upper bound while summing.
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_dv      = 1'b0;
        n_didx    = r_didx;
        n_last    = r_last;
        n_start   = r_start;
        n_low     = r_low;
        n_high    = r_high;
        n_acc     = r_acc;
        n_y_first = r_y_first;
        n_req     = r_req;
        n_req.go  = 1'b0;
        n_eff     = (int'(i_count) > MAX_SAMPLES) ? MAX_SAMPLES : int'(i_count);

        case (r_state)
            SCAN_IDLE: begin
                if (i_go) begin
                    n_low       = i_bound_low;
                    n_high      = i_bound_high;
                    n_req.width = WID_W'(i_bound_high) - WID_W'(i_bound_low);
                    n_last      = (n_eff < 2) ? '0 : ADDR_W'(n_eff - 1);
                    n_addr      = '0;
                    n_acc       = '0;
                    n_start     = '0;
                    n_state     = SCAN_LO;
                end
            end

            SCAN_LO: begin
                n_addr = r_addr + ADDR_W'(1);
                n_dv   = 1'b1;
                n_didx = r_addr;
                if (r_dv) begin
                    if (r_didx == '0) begin
                        n_y_first = rd_y;
                    end
                    if (in_range && cmp_ge) begin
                        // Start found: reread it for the upper bound search.
                        n_start = r_didx;
                        n_addr  = r_didx;
                        n_dv    = 1'b0;
                        n_state = SCAN_HI;
                    end else if (at_last) begin
                        // No start: the result uses the first value alone.
                        n_req.go  = 1'b1;
                        n_req.sum = SUM_W'((r_didx == '0) ? rd_y : r_y_first);
                        n_dv      = 1'b0;
                        n_state   = SCAN_IDLE;
                    end
                end
            end

            SCAN_HI: begin
                n_addr = r_addr + ADDR_W'(1);
                n_dv   = 1'b1;
                n_didx = r_addr;
                if (r_dv) begin
                    if (r_didx == r_start) begin
                        n_y_first = rd_y;
                    end
                    if (cmp_ge) begin
                        n_req.go  = 1'b1;
                        n_req.sum = (r_didx == r_start) ? SUM_W'(rd_y) : r_acc;
                        n_dv      = 1'b0;
                        n_state   = SCAN_IDLE;
                    end else begin
                        n_acc = r_acc + SUM_W'(rd_y);
                        if (at_last) begin
                            // No end: the result uses the start value alone.
                            n_req.go  = 1'b1;
                            n_req.sum = SUM_W'((r_didx == r_start) ? rd_y : r_y_first);
                            n_dv      = 1'b0;
                            n_state   = SCAN_IDLE;
                        end
                    end
                end
            end

            default: begin
                n_state = SCAN_IDLE;
            end
        endcase
    end

    assign o_rd_addr = r_addr;
    assign o_busy    = (r_state != SCAN_IDLE) || r_req.go;
    assign o_req     = r_req;

endmodule

// File: hdl/bscu_mul.sv
`timescale 1ns / 1ps

module bscu_mul import bscu_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mul_req                i_req,
    output logic                    o_busy,
    output logic signed [RES_W-1:0] o_result,
    output logic                    o_valid
);

    t_mul_state r_state, n_state;

    logic [MAG_W-1:0]       r_a, n_a;
    logic [DATA_W-1:0]      r_b, n_b;
    logic                   r_neg, n_neg;
    logic [2*DATA_W-1:0]    r_p0, n_p0;
    logic [HI_W+DATA_W-1:0] r_p1, n_p1;
    logic [RES_W-1:0]       r_mag, n_mag;
    logic [RES_W-1:0]       r_result, n_result;
    logic                   r_valid, n_valid;

    logic [DATA_W-1:0]       mul_a;
    logic [2*DATA_W-1:0]     mul_p;
    logic [SUM_W-1:0]        sum_abs;
    logic [WID_W-1:0]        width_abs;
    logic [PROD_W-1:0]       prod;
    logic [RES_W-1:0]        limit;

    // Magnitudes of the incoming operands.
    assign sum_abs   = i_req.sum[SUM_W-1] ? SUM_W'(-i_req.sum) : SUM_W'(i_req.sum);
    assign width_abs = i_req.width[WID_W-1] ? WID_W'(-i_req.width) : WID_W'(i_req.width);

    // The shared 32 by 32 multiplier takes the low slice, then the high slice.
    assign mul_a = (r_state == MUL_HI) ? DATA_W'(r_a[MAG_W-1:DATA_W]) : r_a[DATA_W-1:0];
    assign mul_p = mul_a * r_b;

    // Partial products joined, and the saturation limit for the sign.
    assign prod  = PROD_W'(r_p0) + {r_p1, {DATA_W{1'b0}}};
    assign limit = r_neg ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MUL_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_b      <= n_b;
        r_neg    <= n_neg;
        r_p0     <= n_p0;
        r_p1     <= n_p1;
        r_mag    <= n_mag;
        r_result <= n_result;
    end

    // Sequencer over the multiply, saturate and sign steps.
    always_comb begin
        n_state  = r_state;
        n_a      = r_a;
        n_b      = r_b;
        n_neg    = r_neg;
        n_p0     = r_p0;
        n_p1     = r_p1;
        n_mag    = r_mag;
        n_result = r_result;
        n_valid  = 1'b0;

        case (r_state)
            MUL_IDLE: begin
                if (i_req.go) begin
                    n_a     = sum_abs[MAG_W-1:0];
                    n_b     = width_abs[DATA_W-1:0];
                    n_neg   = i_req.sum[SUM_W-1] ^ i_req.width[WID_W-1];
                    n_state = MUL_LO;
                end
            end

            MUL_LO: begin
                n_p0    = mul_p;
                n_state = MUL_HI;
            end

            MUL_HI: begin
                n_p1    = mul_p[HI_W+DATA_W-1:0];
                n_state = MUL_SAT;
            end

            MUL_SAT: begin
                n_mag   = (prod > PROD_W'(limit)) ? limit : prod[RES_W-1:0];
                n_state = MUL_OUT;
            end

            MUL_OUT: begin
                n_result = r_neg ? (RES_W'(0) - r_mag) : r_mag;
                n_valid  = 1'b1;
                n_state  = MUL_IDLE;
            end

            default: begin
                n_state = MUL_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != MUL_IDLE);
    assign o_result = $signed(r_result);
    assign o_valid  = r_valid;

endmodule

// File: hdl/band_sum_over_sampled_curve_unit.sv
`timescale 1ns / 1ps

// Band sum over a sampled curve. A load transfer (start high, busy low, req_type 0)
// writes one (x, y) pair and leaves busy low, so loads can follow back to back. A query
// transfer raises busy while the sequencer walks the sample store one entry per cycle:
// first up to sample_count-1 reads to find the start, then from the start on to find
// the end while summing y. The walk stops at the first entry that reaches the upper
// bound, or else at the last entry in range (sample_count clamped to the store size);
// the sum then goes through the shared 32 by 32 multiplier and saturation step, and one
// 64-bit result shows on o_band_result for exactly one cycle with o_band_valid. The
// receiver cannot stall that strobe, and busy is already low in the strobe cycle. The
// user must write the sample count through i_cfg_we/i_cfg_data only while the block
// is idle; the block itself does not enforce this.
module band_sum_over_sampled_curve_unit import bscu_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic                     i_req_type,
    input  logic [IDX_W-1:0]         i_sample_index,
    input  logic signed [DATA_W-1:0] i_sample_x,
    input  logic signed [DATA_W-1:0] i_sample_y,
    input  logic signed [DATA_W-1:0] i_bound_low,
    input  logic signed [DATA_W-1:0] i_bound_high,
    output logic signed [RES_W-1:0]  o_band_result,
    output logic                     o_band_valid,
    input  logic                     i_cfg_we,
    input  logic [CNT_W-1:0]         i_cfg_data
);

    logic [CNT_W-1:0]  r_sample_count;
    logic              accept;
    logic              load_we;
    logic              query_go;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_x;
    logic [DATA_W-1:0] rd_y;
    logic              scan_busy;
    logic              mul_busy;
    t_mul_req          mul_req;

    // Sample count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= SAMPLE_COUNT_RST;
        end else if (i_cfg_we) begin
            r_sample_count <= i_cfg_data;
        end
    end

    // Transfer decode.
    assign accept   = i_start && !o_busy;
    assign load_we  = accept && (i_req_type == REQ_LOAD)
                      && (int'(i_sample_index) < MAX_SAMPLES);
    assign query_go = accept && (i_req_type == REQ_QUERY);

    // Abscissa and value stores.
    bscu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_SAMPLES)
    ) u_abscissa_store (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (ADDR_W'(i_sample_index)),
        .i_wdata (i_sample_x),
        .i_raddr (rd_addr),
        .o_rdata (rd_x)
    );

    bscu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_SAMPLES)
    ) u_value_store (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (ADDR_W'(i_sample_index)),
        .i_wdata (i_sample_y),
        .i_raddr (rd_addr),
        .o_rdata (rd_y)
    );

    // Search and sum sequencer.
    bscu_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (query_go),
        .i_count      (r_sample_count),
        .i_bound_low  (i_bound_low),
        .i_bound_high (i_bound_high),
        .o_rd_addr    (rd_addr),
        .i_rd_x       (rd_x),
        .i_rd_y       (rd_y),
        .o_busy       (scan_busy),
        .o_req        (mul_req)
    );

    // Saturating multiply by the band width.
    bscu_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mul_req),
        .o_busy   (mul_busy),
        .o_result (o_band_result),
        .o_valid  (o_band_valid)
    );

    assign o_busy = scan_busy || mul_busy;

endmodule

// File: hdl/bscu_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bscu_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic i_req_type,
    input logic o_band_valid
);

    // A load transfer completes in its own cycle and leaves the block free.
    `CHK_NEXT(a_load_stays_free, i_start && !o_busy && !i_req_type, !o_busy, "load made the block busy")

    // A query transfer that is taken raises busy.
    `CHK_NEXT(a_query_goes_busy, i_start && !o_busy && i_req_type, o_busy, "query did not raise busy")

    // Each result strobe is a single cycle.
    `CHK_NEXT(a_strobe_single, o_band_valid, !o_band_valid, "result strobe held over two cycles")

    // A result follows busy work and arrives with the block free again.
    `CHK_ASSERT(a_result_after_work, o_band_valid |-> ($past(o_busy) && !o_busy), "result outside a query")

endmodule

bind band_sum_over_sampled_curve_unit bscu_checker u_bscu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (i_start),
    .o_busy       (o_busy),
    .i_req_type   (i_req_type),
    .o_band_valid (o_band_valid)
);

// File: sim/band_sum_checker.sv
`timescale 1ns / 1ps

// Watches the transfers of the band sum unit, predicts each band result from its own
// copy of the sample store and the sample count, and compares it with what arrives.
module band_sum_checker import bscu_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_busy,
    input  logic                     i_req_type,
    input  logic [IDX_W-1:0]         i_sample_index,
    input  logic signed [DATA_W-1:0] i_sample_x,
    input  logic signed [DATA_W-1:0] i_sample_y,
    input  logic signed [DATA_W-1:0] i_bound_low,
    input  logic signed [DATA_W-1:0] i_bound_high,
    input  logic signed [RES_W-1:0]  i_band_result,
    input  logic                     i_band_valid,
    input  logic                     i_cfg_we,
    input  logic [CNT_W-1:0]         i_cfg_data,
    output int                       o_pending,
    output int                       o_fail_count
);

    // Saturation limits of the Q32.32 result, held in a product-wide signed type.
    localparam logic signed [127:0] PROD_MAX = (128'sd1 <<< 63) - 128'sd1;
    localparam logic signed [127:0] PROD_MIN = -(128'sd1 <<< 63);

    logic signed [DATA_W-1:0] abscissa_mem [MAX_SAMPLES];
    logic signed [DATA_W-1:0] value_mem [MAX_SAMPLES];
    logic [CNT_W-1:0]         count_reg;
    logic signed [RES_W-1:0]  band_queue [$];
    logic signed [RES_W-1:0]  want;

    initial begin
        count_reg    = SAMPLE_COUNT_RST;
        o_pending    = 0;
        o_fail_count = 0;
    end

    // Locate the band on the stored curve, sum the values inside it and scale the sum
    // by the band width with exact arithmetic, then clamp to the 64-bit range.
    function automatic logic signed [RES_W-1:0] band_sum_times_width(
        input logic signed [DATA_W-1:0] lo,
        input logic signed [DATA_W-1:0] hi
    );
        int                  n;
        int                  span;
        int                  j;
        int                  first;
        int                  stop;
        logic signed [63:0]  total;
        logic signed [63:0]  width;
        logic signed [127:0] prod;
        n    = (count_reg > MAX_SAMPLES) ? MAX_SAMPLES : int'(count_reg);
        span = (n < 2) ? 0 : n - 1;
        // The start is the first abscissa reaching the lower bound, else index 0.
        j = 0;
        while (j < span && abscissa_mem[j] < lo) j++;
        first = (j < span) ? j : 0;
        // The end search goes on from the start; without a hit the end is the start.
        stop = first;
        while (j < span && abscissa_mem[j] < hi) j++;
        if (j < span) stop = j;
        if (first == stop) begin
            total = value_mem[first];
        end else begin
            total = 0;
            for (int k = first; k < stop; k++) total += value_mem[k];
        end
        width = hi - lo;
        prod  = total * width;
        if (prod > PROD_MAX) prod = PROD_MAX;
        if (prod < PROD_MIN) prod = PROD_MIN;
        return prod[RES_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            count_reg = SAMPLE_COUNT_RST;
            band_queue.delete();
        end else begin
            // A result transfer is matched against the oldest prediction.
            if (i_band_valid) begin
                if (band_queue.size() == 0) begin
                    $error("band_result: no result expected, actual %0d", i_band_result);
                    o_fail_count++;
                end else begin
                    want = band_queue.pop_front();
                    if (i_band_result !== want) begin
                        $error("band_result: expected %0d, actual %0d", want, i_band_result);
                        o_fail_count++;
                    end
                end
            end
            // Input transfers: loads update the store copy, queries queue a prediction.
            if (i_start && !i_busy) begin
                if (i_req_type == REQ_LOAD) begin
                    abscissa_mem[i_sample_index] = i_sample_x;
                    value_mem[i_sample_index]    = i_sample_y;
                end else begin
                    band_queue.push_back(band_sum_times_width(i_bound_low, i_bound_high));
                end
            end
            // Sample count writes apply from the next edge on.
            if (i_cfg_we) count_reg = i_cfg_data;
        end
        o_pending = band_queue.size();
    end

endmodule

// File: sim/tb_band_sum_over_sampled_curve_unit.sv
`timescale 1ns / 1ps

module tb_band_sum_over_sampled_curve_unit;
    import bscu_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 5_000_000;
    localparam int          PHASE_ITEMS  = 18;
    localparam int          FILL_TOP_MAX = 40;
    localparam logic signed [DATA_W-1:0] X_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] X_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] X_ONE = 32'sh0001_0000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_start;
    logic                     o_busy;
    logic                     i_req_type;
    logic [IDX_W-1:0]         i_sample_index;
    logic signed [DATA_W-1:0] i_sample_x;
    logic signed [DATA_W-1:0] i_sample_y;
    logic signed [DATA_W-1:0] i_bound_low;
    logic signed [DATA_W-1:0] i_bound_high;
    logic signed [RES_W-1:0]  o_band_result;
    logic                     o_band_valid;
    logic                     i_cfg_we;
    logic [CNT_W-1:0]         i_cfg_data;

    int          pending_bands;
    int          fail_count;
    int unsigned cycle_count = 0;
    int          idle_pct;
    int          span_top;
    int          fill_top;
    int          guard_idx;
    int          sweep_counts [12] = '{2, 5, 16, 3, 31, 64, 8, 128, 2, 45, 200, 11};
    int          idle_levels [3] = '{0, 72, 33};
    logic signed [DATA_W-1:0] x_shadow [MAX_SAMPLES];

    always #5 i_clk = ~i_clk;

    band_sum_over_sampled_curve_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_req_type     (i_req_type),
        .i_sample_index (i_sample_index),
        .i_sample_x     (i_sample_x),
        .i_sample_y     (i_sample_y),
        .i_bound_low    (i_bound_low),
        .i_bound_high   (i_bound_high),
        .o_band_result  (o_band_result),
        .o_band_valid   (o_band_valid),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    band_sum_checker u_band_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_busy         (o_busy),
        .i_req_type     (i_req_type),
        .i_sample_index (i_sample_index),
        .i_sample_x     (i_sample_x),
        .i_sample_y     (i_sample_y),
        .i_bound_low    (i_bound_low),
        .i_bound_high   (i_bound_high),
        .i_band_result  (o_band_result),
        .i_band_valid   (o_band_valid),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_pending      (pending_bands),
        .o_fail_count   (fail_count)
    );

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("band_sum_over_sampled_curve_unit: mismatch");
            $finish;
        end
    end

    function automatic logic signed [DATA_W-1:0] clamp_x(input longint v);
        if (v > longint'(X_MAX)) return X_MAX;
        if (v < longint'(X_MIN)) return X_MIN;
        return DATA_W'(v);
    endfunction

    // Sample values: the extremes, full-range noise, and half the time small Q16.16 numbers.
    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return X_MIN;
            1: return X_MAX;
            2, 3: return $urandom;
            default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    // Band bounds mostly land on or right beside a stored abscissa.
    function automatic logic signed [DATA_W-1:0] pick_bound();
        logic signed [DATA_W-1:0] near;
        near = x_shadow[$urandom_range(0, fill_top)];
        case ($urandom_range(0, 9))
            0: return X_MIN;
            1: return X_MAX;
            2: return $urandom;
            3: return clamp_x(longint'(near) + int'($urandom_range(1, 3)));
            4: return clamp_x(longint'(near) - int'($urandom_range(1, 3)));
            default: return near;
        endcase
    endfunction

    // One transfer: the item stays on the inputs with start high until the block takes it.
    task automatic send_item(
        input logic                     req,
        input logic [IDX_W-1:0]         idx,
        input logic signed [DATA_W-1:0] x,
        input logic signed [DATA_W-1:0] y,
        input logic signed [DATA_W-1:0] lo,
        input logic signed [DATA_W-1:0] hi
    );
        i_start        <= 1'b1;
        i_req_type     <= req;
        i_sample_index <= idx;
        i_sample_x     <= x;
        i_sample_y     <= y;
        i_bound_low    <= lo;
        i_bound_high   <= hi;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // The guard entry always holds the largest abscissa, so no search walks past it.
    task automatic load_sample(
        input int                       idx,
        input logic signed [DATA_W-1:0] x,
        input logic signed [DATA_W-1:0] y
    );
        if (idx == guard_idx) x = X_MAX;
        x_shadow[idx] = x;
        send_item(REQ_LOAD, IDX_W'(idx), x, y, $urandom, $urandom);
    endtask

    task automatic query_band(input logic signed [DATA_W-1:0] lo, input logic signed [DATA_W-1:0] hi);
        send_item(REQ_QUERY, IDX_W'($urandom), $urandom, $urandom, lo, hi);
    endtask

    // Random sender gap; now and then a long one that spans a whole query walk.
    task automatic sender_gap();
        int gap;
        if ($urandom_range(0, 99) < idle_pct) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(1, 3);
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Hold the sender off until every predicted band result has come back.
    task automatic wait_results();
        i_start <= 1'b0;
        @(negedge i_clk);
        while (pending_bands != 0 || o_busy) @(negedge i_clk);
    endtask

    // The sample count is written only with the block idle; span_top tracks the
    // highest store entry that a query can then read. For large counts only a
    // prefix of the store is filled, closed by a guard entry that stops every search.
    task automatic write_count(input int value);
        wait_results();
        repeat (4) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= CNT_W'(value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (value >= MAX_SAMPLES) span_top = MAX_SAMPLES - 2;
        else if (value < 2) span_top = 0;
        else span_top = value - 2;
        if (span_top + 1 > FILL_TOP_MAX) begin
            fill_top  = FILL_TOP_MAX;
            guard_idx = FILL_TOP_MAX;
        end else begin
            fill_top  = span_top + 1;
            guard_idx = -1;
        end
    endtask

    // Write every entry a query can reach, plus one when there is no guard entry:
    // usually a rising curve with random steps and repeats, sometimes scattered abscissas.
    task automatic fill_curve();
        longint pos;
        longint stride;
        bit     scattered;
        stride    = longint'(1) << $urandom_range(2, 26);
        scattered = ($urandom_range(0, 5) == 0);
        pos       = -((stride * fill_top) >>> 1) - longint'($urandom_range(0, 255));
        for (int i = 0; i <= fill_top; i++) begin
            sender_gap();
            load_sample(i, scattered ? rand_value() : clamp_x(pos), rand_value());
            pos += longint'($urandom) % stride;
        end
    endtask

    // One setting of the sample count: fresh curve, then a mix of queries and loads.
    task automatic run_phase(input int count, input int items);
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        logic signed [DATA_W-1:0] tmp;
        write_count(count);
        fill_curve();
        for (int i = 0; i < items; i++) begin
            sender_gap();
            if ($urandom_range(0, 29) == 0) wait_results();
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 2) == 0) begin
                    load_sample($urandom_range(0, MAX_SAMPLES - 1), rand_value(), rand_value());
                end else begin
                    load_sample($urandom_range(0, fill_top), pick_bound(), rand_value());
                end
            end else begin
                lo = pick_bound();
                hi = pick_bound();
                // Most bands are ordered; the rest stay inverted.
                if (hi < lo && $urandom_range(0, 3) != 0) begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
                query_band(lo, hi);
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_req_type     = REQ_LOAD;
        i_sample_index = '0;
        i_sample_x     = '0;
        i_sample_y     = '0;
        i_bound_low    = '0;
        i_bound_high   = '0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        idle_pct       = 0;
        span_top       = 0;
        fill_top       = 0;
        guard_idx      = -1;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a four-sample curve with extreme abscissas and values.
        write_count(4);
        load_sample(0, X_MIN, X_MAX);
        load_sample(1, 0, X_MIN);
        load_sample(2, X_ONE, X_ONE);
        load_sample(3, X_MAX, 1);
        load_sample(MAX_SAMPLES - 1, -1, -1);
        // Start at the first sample and no abscissa in the search range reaches the upper bound.
        query_band(X_MIN, X_MAX);
        // No abscissa in the search range reaches the lower bound, and the band is inverted.
        query_band(X_MAX, X_MIN);
        // Band between two stored abscissas.
        query_band(0, X_ONE);
        // Sum over two samples.
        query_band(X_MIN, 1);
        // Zero band width.
        query_band(0, 0);
        // Large positive sum over a wide band saturates high.
        load_sample(0, X_MIN, X_MAX);
        load_sample(1, 0, X_MAX);
        query_band(X_MIN, X_ONE);
        // Large negative sum saturates low.
        load_sample(0, X_MIN, X_MIN);
        load_sample(1, 0, X_MIN);
        query_band(X_MIN, X_ONE);
        // Counts below two leave the search range empty.
        write_count(1);
        query_band(X_MIN, X_MAX);
        write_count(0);
        query_band(X_MAX, X_MIN);

        // Random sweep over sample counts and sender idling.
        for (int p = 0; p < 12; p++) begin
            idle_pct = idle_levels[p % 3];
            run_phase(sweep_counts[p], PHASE_ITEMS);
        end
        // A count beyond the store size, then a count equal to it.
        idle_pct = 33;
        run_phase(2047, 6);
        idle_pct = 0;
        run_phase(MAX_SAMPLES, 10);

        // Drain and let any stray strobe show up.
        wait_results();
        repeat (16) @(negedge i_clk);
        if (fail_count == 0 && pending_bands == 0) begin
            $display("band_sum_over_sampled_curve_unit: match");
        end else begin
            $display("band_sum_over_sampled_curve_unit: mismatch");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/bscu_pkg.sv
hdl/bscu_ram.sv
hdl/bscu_scan.sv
hdl/bscu_mul.sv
hdl/band_sum_over_sampled_curve_unit.sv
hdl/bscu_checker.sv
sim/band_sum_checker.sv
sim/tb_band_sum_over_sampled_curve_unit.sv
